// ===== hdl/top_k_weight_selector_defines.svh =====
// assertion macros used by the selector controller
`ifndef TOP_K_WEIGHT_SELECTOR_DEFINES_SVH
`define TOP_K_WEIGHT_SELECTOR_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define TKS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define TKS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tks_pkg.sv =====
`default_nettype none

package tks_pkg;

    // store depth and derived widths
    localparam int MAX_KEEP = 16;
    localparam int CNT_W    = $clog2(MAX_KEEP + 1);
    localparam int IDX_W    = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

    // field widths fixed by the interface
    localparam int ID_W    = 32;
    localparam int SCORE_W = 32;
    localparam int FREQ_W  = 32;
    localparam int MATCH_W = 8;
    localparam int KEEP_W  = 5;

    // request operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DRAIN  = 1'b1;

    // one kept entry
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [SCORE_W-1:0] score;
        logic [FREQ_W-1:0]  freq;
        logic [MATCH_W-1:0] match_cnt;
    } entry_t;

    // controller to datapath commands
    typedef struct packed {
        logic             ins_en;
        logic [CNT_W-1:0] ins_fill;
        logic             pop_en;
        logic [CNT_W-1:0] fill;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic min_above;
    } dp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/tks_datapath.sv =====
`default_nettype none

module tks_datapath (
    input  wire logic             aclk,
    input  wire tks_pkg::entry_t  new_entry,
    input  wire tks_pkg::dp_cmd_t cmd,
    output tks_pkg::dp_sts_t      sts,
    output tks_pkg::entry_t       head_entry
);
    import tks_pkg::*;

    entry_t             cell_reg  [MAX_KEEP];
    entry_t             cell_next [MAX_KEEP];
    logic [MAX_KEEP-1:0] ahead;
    logic [MAX_KEEP-1:0] above;
    logic [CNT_W-1:0]    min_pos;

    // per-cell compare against the incoming entry
    always_comb begin
        for (int k = 0; k < MAX_KEEP; k++) begin
            above[k] = $signed(cell_reg[k].score) > $signed(new_entry.score);
            ahead[k] = (CNT_W'(k) < cmd.ins_fill) &&
                       (above[k] ||
                        ((cell_reg[k].score == new_entry.score) &&
                         (cell_reg[k].id <= new_entry.id)));
        end
    end

    // current minimum sits in the last occupied cell
    assign min_pos       = cmd.fill - CNT_W'(1);
    assign sts.min_above = (cmd.fill != '0) && above[min_pos[IDX_W-1:0]];

    // insertion shifts the tail down, pop shifts the chain up
    always_comb begin
        for (int k = 0; k < MAX_KEEP; k++) begin
            cell_next[k] = cell_reg[k];
        end
        if (cmd.ins_en) begin
            if (!ahead[0]) begin
                cell_next[0] = new_entry;
            end
            for (int k = 1; k < MAX_KEEP; k++) begin
                if (!ahead[k]) begin
                    cell_next[k] = ahead[k-1] ? new_entry : cell_reg[k-1];
                end
            end
        end else if (cmd.pop_en) begin
            for (int k = 0; k < MAX_KEEP - 1; k++) begin
                cell_next[k] = cell_reg[k+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < MAX_KEEP; k++) begin
            cell_reg[k] <= cell_next[k];
        end
    end

    assign head_entry = cell_reg[0];

endmodule

`default_nettype wire

// ===== hdl/tks_controller.sv =====
`default_nettype none

module tks_controller (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [tks_pkg::KEEP_W-1:0]  cfg_wr_data,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic                        s_operation,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_last_entry,
    input  wire tks_pkg::dp_sts_t            sts,
    output tks_pkg::dp_cmd_t                 cmd
);
    import tks_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [KEEP_W-1:0] keep_reg, keep_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic [CNT_W-1:0]  limit;
    logic              full;
    logic              in_take;
    logic              out_take;
    logic              drop;

    // effective limit, saturated to the store depth
    assign limit = (32'(keep_reg) > 32'(MAX_KEEP)) ? CNT_W'(MAX_KEEP) : CNT_W'(keep_reg);
    assign full  = fill_reg >= limit;
    assign drop  = (limit == '0) || (full && sts.min_above);

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = (state_reg == ST_DRAIN);
    assign m_last_entry = (remain_reg == CNT_W'(1));
    assign in_take      = s_valid && s_ready;
    assign out_take     = m_valid && m_ready;

    // sequencing of insert and drain requests
    always_comb begin
        state_next   = state_reg;
        keep_next    = cfg_wr_en ? cfg_wr_data : keep_reg;
        fill_next    = fill_reg;
        remain_next  = remain_reg;
        cmd.ins_en   = 1'b0;
        cmd.ins_fill = full ? fill_reg - CNT_W'(1) : fill_reg;
        cmd.pop_en   = 1'b0;
        cmd.fill     = fill_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_take && (s_operation == OP_INSERT)) begin
                    if (!drop) begin
                        cmd.ins_en = 1'b1;
                        fill_next  = cmd.ins_fill + CNT_W'(1);
                    end
                end else if (in_take) begin
                    fill_next   = '0;
                    remain_next = fill_reg;
                    if (fill_reg != '0) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (out_take) begin
                    cmd.pop_en  = 1'b1;
                    remain_next = remain_reg - CNT_W'(1);
                    if (m_last_entry) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            keep_reg   <= KEEP_W'(16);
            fill_reg   <= '0;
            remain_reg <= '0;
        end else begin
            state_reg  <= state_next;
            keep_reg   <= keep_next;
            fill_reg   <= fill_next;
            remain_reg <= remain_next;
        end
    end

`include "top_k_weight_selector_defines.svh"

    `TKS_ASSERT_NOW(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= CNT_W'(MAX_KEEP), "fill above depth")
    `TKS_ASSERT_NOW(a_drain_nonempty, aclk, aresetn, state_reg == ST_DRAIN, remain_reg != '0, "drain with nothing left")
    `TKS_ASSERT_NEXT(a_drain_start, aclk, aresetn, in_take && (s_operation == OP_DRAIN) && (fill_reg != '0), (state_reg == ST_DRAIN) && (fill_reg == '0), "drain did not start")
    `TKS_ASSERT_NEXT(a_drain_end, aclk, aresetn, out_take && m_last_entry, state_reg == ST_IDLE, "drain did not end on last")

endmodule

`default_nettype wire

// ===== hdl/top_k_weight_selector.sv =====
// channel   direction  handshake          payload
// s_        in         s_valid/s_ready    operation, entry_id, score, freq_total, match_count
// m_        out        m_valid/m_ready    out_id, out_score, out_freq_total, out_match_count,
//                                         last_entry
// cfg_      in         cfg_wr_en          keep_count (5 bits)
//
// an insert request is taken and placed in the sorted cell chain unless it is dropped
// a drain request emits one kept entry per cycle from the head cell while m_ready is high
// new requests wait while a drain is delivering (s_ready low in drain)
// synchronous active-low reset clears fill and sets keep_count to 16; cells hold no reset
`default_nettype none

module top_k_weight_selector (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [tks_pkg::KEEP_W-1:0]   cfg_wr_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_operation,
    input  wire logic [tks_pkg::ID_W-1:0]     s_entry_id,
    input  wire logic signed [tks_pkg::SCORE_W-1:0] s_score,
    input  wire logic [tks_pkg::FREQ_W-1:0]   s_freq_total,
    input  wire logic [tks_pkg::MATCH_W-1:0]  s_match_count,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic [tks_pkg::ID_W-1:0]          m_out_id,
    output logic signed [tks_pkg::SCORE_W-1:0] m_out_score,
    output logic [tks_pkg::FREQ_W-1:0]        m_out_freq_total,
    output logic [tks_pkg::MATCH_W-1:0]       m_out_match_count,
    output logic                              m_last_entry
);
    import tks_pkg::*;

    entry_t  new_entry;
    entry_t  head_entry;
    dp_cmd_t cmd;
    dp_sts_t sts;

    // pack the incoming request
    assign new_entry.id        = s_entry_id;
    assign new_entry.score     = s_score;
    assign new_entry.freq      = s_freq_total;
    assign new_entry.match_cnt = s_match_count;

    tks_controller u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_last_entry (m_last_entry),
        .sts          (sts),
        .cmd          (cmd)
    );

    tks_datapath u_dp (
        .aclk       (aclk),
        .new_entry  (new_entry),
        .cmd        (cmd),
        .sts        (sts),
        .head_entry (head_entry)
    );

    // head cell drives the result
    assign m_out_id          = head_entry.id;
    assign m_out_score       = $signed(head_entry.score);
    assign m_out_freq_total  = head_entry.freq;
    assign m_out_match_count = head_entry.match_cnt;

endmodule

`default_nettype wire
